FILE: hw/rtl/top_k_insertion_list_assert.svh
// Assertion helpers for the top-k insertion list.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef TOP_K_INSERTION_LIST_ASSERT_SVH
`define TOP_K_INSERTION_LIST_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TKIL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("top_k_insertion_list: check failed");

// Consequent checked in the cycle after the antecedent.
`define TKIL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("top_k_insertion_list: check failed");

`endif

FILE: hw/rtl/tkil_pkg.sv
`timescale 1ns / 1ps

package tkil_pkg;

  localparam int unsigned TKIL_LIST_DEPTH = 10;
  localparam int unsigned WEIGHT_W        = 20;
  localparam int unsigned TAG_W           = 21;
  localparam int unsigned PAYLOAD_W       = WEIGHT_W + TAG_W;
  localparam int unsigned TDATA_W         = ((PAYLOAD_W + 7) / 8) * 8;

  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [TAG_W-1:0]    tag_t;

  localparam weight_t EMPTY_WEIGHT_RST = weight_t'(100000);

  typedef struct packed {
    logic    used;
    weight_t weight;
    tag_t    tag;
  } slot_entry_t;

  // Per-cycle command from the sequencer to every cell of the chain
  typedef struct packed {
    logic ins_en;     // candidate accepted and below the empty weight
    logic shift_out;  // readout: each cell takes its successor's entry
  } cell_ctrl_t;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } tkil_state_e;

endpackage

FILE: hw/rtl/tkil_cell.sv
`timescale 1ns / 1ps

module tkil_cell
  import tkil_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cell_ctrl_t  ctrl_i,
  input  weight_t     cand_weight_i,
  input  tag_t        cand_tag_i,
  input  weight_t     empty_weight_i,
  input  logic        prev_gt_i,
  input  slot_entry_t prev_entry_i,
  input  slot_entry_t next_entry_i,
  output logic        gt_o,
  output slot_entry_t entry_o
);

  logic    used_q, used_d;
  weight_t weight_q, weight_d;
  tag_t    tag_q, tag_d;
  weight_t cmp_weight;

  // empty slots rank with the current empty weight
  assign cmp_weight = used_q ? weight_q : empty_weight_i;
  assign gt_o       = cmp_weight > cand_weight_i;

  always_comb begin
    used_d   = used_q;
    weight_d = weight_q;
    tag_d    = tag_q;
    if (ctrl_i.shift_out) begin
      used_d   = next_entry_i.used;
      weight_d = next_entry_i.weight;
      tag_d    = next_entry_i.tag;
    end else if (ctrl_i.ins_en && gt_o) begin
      if (prev_gt_i) begin
        // insertion point lies above: move down one rank
        used_d   = prev_entry_i.used;
        weight_d = prev_entry_i.weight;
        tag_d    = prev_entry_i.tag;
      end else begin
        used_d   = 1'b1;
        weight_d = cand_weight_i;
        tag_d    = cand_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    weight_q <= weight_d;
    tag_q    <= tag_d;
  end

  assign entry_o = {used_q, weight_q, tag_q};

endmodule

FILE: hw/rtl/tkil_ctrl.sv
`timescale 1ns / 1ps

module tkil_ctrl
  import tkil_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = TKIL_LIST_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_last_i,
  input  logic       weight_ok_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       out_last_o,
  output cell_ctrl_t cell_ctrl_o
);

  localparam int unsigned RANK_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(LIST_DEPTH - 1);

  tkil_state_e       state_q, state_d;
  logic [RANK_W-1:0] rank_q, rank_d;

  always_comb begin
    state_d     = state_q;
    rank_d      = rank_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    out_last_o  = 1'b0;
    cell_ctrl_o = '0;
    case (state_q)
      ST_COLLECT: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cell_ctrl_o.ins_en = weight_ok_i;
          if (in_last_i) begin
            state_d = ST_EMIT;
            rank_d  = '0;
          end
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        out_last_o  = (rank_q == LAST_RANK);
        if (out_ready_i) begin
          // the chain moves up one rank; empties fill in from the tail
          cell_ctrl_o.shift_out = 1'b1;
          if (rank_q == LAST_RANK) begin
            state_d = ST_COLLECT;
          end else begin
            rank_d = rank_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      rank_q  <= '0;
    end else begin
      state_q <= state_d;
      rank_q  <= rank_d;
    end
  end

endmodule

FILE: hw/rtl/top_k_insertion_list.sv
`timescale 1ns / 1ps
// Channel   Direction  Contents
// s_axis    in         tdata: cand_weight, cand_tag; tlast: last_item
// m_axis    out        tdata: rank_weight, rank_tag; tuser: slot_filled; tlast: last_rank
// cfg       in         cfg_wr_en_i / cfg_wr_data_i: empty_weight
//
// The chain of cells compares each candidate in every cell at once.
// A transaction with tlast starts readout in the next cycle: LIST_DEPTH output transactions,
// one per cycle while m_axis_tready_i is high, and no input is taken until the last one.
// Readout shifts the chain towards rank 0, so the list is empty once it ends.
// Reset empties all slots and sets empty_weight to 100000.

module top_k_insertion_list
  import tkil_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = TKIL_LIST_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [TDATA_W-1:0] s_axis_tdata_i,   // [19:0] cand_weight, [40:20] cand_tag
  input  logic               s_axis_tlast_i,   // last_item
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [TDATA_W-1:0] m_axis_tdata_o,   // [19:0] rank_weight, [40:20] rank_tag
  output logic               m_axis_tuser_o,   // slot_filled
  output logic               m_axis_tlast_o,   // last_rank
  input  logic               cfg_wr_en_i,
  input  weight_t            cfg_wr_data_i     // empty_weight
);

  weight_t     empty_weight_q;
  weight_t     cand_weight;
  tag_t        cand_tag;
  logic        weight_ok;
  cell_ctrl_t  cell_ctrl;
  logic        gt_chain  [LIST_DEPTH+1];
  slot_entry_t ent_chain [LIST_DEPTH+2];
  slot_entry_t head;

  assign cand_weight = s_axis_tdata_i[WEIGHT_W-1:0];
  assign cand_tag    = s_axis_tdata_i[PAYLOAD_W-1:WEIGHT_W];
  assign weight_ok   = cand_weight < empty_weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_weight_q <= EMPTY_WEIGHT_RST;
    end else if (cfg_wr_en_i) begin
      empty_weight_q <= cfg_wr_data_i;
    end
  end

  tkil_ctrl #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .weight_ok_i (weight_ok),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_last_o  (m_axis_tlast_o),
    .cell_ctrl_o (cell_ctrl)
  );

  // ent_chain[i+1] is cell i; both ends are empty placeholders
  assign gt_chain[0]             = 1'b0;
  assign ent_chain[0]            = '0;
  assign ent_chain[LIST_DEPTH+1] = '0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    tkil_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (cell_ctrl),
      .cand_weight_i  (cand_weight),
      .cand_tag_i     (cand_tag),
      .empty_weight_i (empty_weight_q),
      .prev_gt_i      (gt_chain[i]),
      .prev_entry_i   (ent_chain[i]),
      .next_entry_i   (ent_chain[i+2]),
      .gt_o           (gt_chain[i+1]),
      .entry_o        (ent_chain[i+1])
    );
  end

  assign head           = ent_chain[1];
  assign m_axis_tuser_o = head.used;
  assign m_axis_tdata_o = {(TDATA_W - PAYLOAD_W)'(0),
                           head.used ? head.tag : tag_t'(0),
                           head.used ? head.weight : empty_weight_q};

endmodule

FILE: hw/rtl/tkil_checker.sv
`timescale 1ns / 1ps
`include "top_k_insertion_list_assert.svh"

module tkil_checker
  import tkil_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid_i,
  input logic               s_axis_tready_o,
  input logic               s_axis_tlast_i,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [TDATA_W-1:0] m_axis_tdata_o,
  input logic               m_axis_tuser_o,
  input logic               m_axis_tlast_o
);

  logic             in_fire;
  logic             out_fire;
  logic             out_stall;
  logic [TDATA_W:0] out_beat;

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire  = m_axis_tvalid_o && m_axis_tready_i;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_beat  = {m_axis_tuser_o, m_axis_tdata_o};

  // readout and collection never overlap
  `TKIL_ASSERT_SAME(a_no_accept_in_readout, m_axis_tvalid_o, !s_axis_tready_o)
  // a final candidate starts readout straight away
  `TKIL_ASSERT_NEXT(a_last_starts_readout, in_fire && s_axis_tlast_i, m_axis_tvalid_o)
  // after the final rank the block collects again
  `TKIL_ASSERT_NEXT(a_readout_ends, out_fire && m_axis_tlast_o, s_axis_tready_o && !m_axis_tvalid_o)
  // empty slots carry tag zero
  `TKIL_ASSERT_SAME(a_empty_tag_zero, out_stall || out_fire, m_axis_tuser_o || out_beat[PAYLOAD_W-1:WEIGHT_W] == '0)
  // a stalled output transaction holds
  `TKIL_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid_o && $stable(out_beat))

endmodule

bind top_k_insertion_list tkil_checker u_tkil_checker (.*);

FILE: tb/top_k_insertion_list_test.sv
`timescale 1ns / 1ps

module top_k_insertion_list_test;
  import tkil_pkg::*;

  localparam int unsigned DEPTH      = TKIL_LIST_DEPTH;
  localparam int unsigned DRAIN_WAIT = DEPTH + 6;
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam weight_t     WEIGHT_MAX = '1;
  localparam tag_t        TAG_MAX    = tag_t'(1114111);

  typedef struct packed {
    weight_t weight;
    tag_t    tag;
    logic    filled;
    logic    last;
  } rank_t;

  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_PATTERN,
    RX_SLOW
  } rx_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;     // [19:0] cand_weight, [40:20] cand_tag
  logic               s_tlast = 1'b0;   // last_item
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;          // [19:0] rank_weight, [40:20] rank_tag
  logic               m_tuser;          // slot_filled
  logic               m_tlast;          // last_rank
  logic               cfg_wr_en = 1'b0;
  weight_t            cfg_wr_data = '0;

  top_k_insertion_list dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_wr_data_i   (cfg_wr_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow copy of the list
  weight_t  empty_w = EMPTY_WEIGHT_RST;
  weight_t  held_weight [DEPTH];
  tag_t     held_tag    [DEPTH];
  bit       held_used   [DEPTH];
  weight_t  tie_pool    [4];
  rank_t    expected_ranks[$];

  rx_mode_e    rx_mode = RX_OPEN;
  bit          tx_gaps = 1'b0;
  int unsigned burst_left = 0;
  int unsigned rx_tick = 0;
  int unsigned cycles = 0;
  int unsigned fail_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned cand_count = 0;
  int unsigned rank_count = 0;
  int unsigned frame_count = 0;
  int unsigned cfg_count = 0;
  rank_t       got_rank;
  rank_t       want_rank;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d ranks still due", cycles,
               expected_ranks.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_OPEN:    m_tready <= 1'b1;
      RX_RANDOM:  m_tready <= ($urandom_range(3, 0) != 0);
      RX_PATTERN: m_tready <= ((rx_tick % 11) < 6);
      default:    m_tready <= ($urandom_range(4, 0) == 0);
    endcase
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------
  task automatic rank_insert(input weight_t w, input tag_t tag);
    int pos;
    weight_t cmp;
    pos = 0;
    if (w >= empty_w) return;
    while (pos < DEPTH) begin
      cmp = held_used[pos] ? held_weight[pos] : empty_w;
      if (cmp > w) break;
      pos++;
    end
    if (pos >= DEPTH) return;
    for (int j = DEPTH - 1; j > pos; j--) begin
      held_weight[j] = held_weight[j-1];
      held_tag[j]    = held_tag[j-1];
      held_used[j]   = held_used[j-1];
    end
    held_weight[pos] = w;
    held_tag[pos]    = tag;
    held_used[pos]   = 1'b1;
  endtask

  task automatic rank_emit();
    rank_t r;
    for (int k = 0; k < DEPTH; k++) begin
      r.weight = held_used[k] ? held_weight[k] : empty_w;
      r.tag    = held_used[k] ? held_tag[k] : '0;
      r.filled = held_used[k];
      r.last   = (k == DEPTH - 1);
      expected_ranks.push_back(r);
      held_used[k] = 1'b0;
      held_tag[k]  = '0;
    end
    frame_count++;
  endtask

  // ---------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------
  task automatic note_mismatch(input string what, input rank_t want, input rank_t got);
    fail_count++;
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] %s: want w=%0d tag=%0d fill=%0b last=%0b, got w=%0d tag=%0d fill=%0b last=%0b",
               $realtime, what, want.weight, want.tag, want.filled, want.last,
               got.weight, got.tag, got.filled, got.last);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      got_rank.weight = m_tdata[WEIGHT_W-1:0];
      got_rank.tag    = m_tdata[WEIGHT_W +: TAG_W];
      got_rank.filled = m_tuser;
      got_rank.last   = m_tlast;
      if (expected_ranks.size() == 0) begin
        note_mismatch("unexpected rank", '0, got_rank);
      end else begin
        want_rank = expected_ranks.pop_front();
        rank_count++;
        if (got_rank.weight !== want_rank.weight)
          note_mismatch("rank_weight", want_rank, got_rank);
        if (got_rank.tag !== want_rank.tag)
          note_mismatch("rank_tag", want_rank, got_rank);
        if (got_rank.filled !== want_rank.filled)
          note_mismatch("slot_filled", want_rank, got_rank);
        if (got_rank.last !== want_rank.last)
          note_mismatch("last_rank", want_rank, got_rank);
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------
  task automatic send_cand(input weight_t w, input tag_t tag, input logic is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = tx_gaps ? $urandom_range(5, 0) : 0;
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= TDATA_W'({tag, w});
    s_tlast  <= is_last;
    do @(posedge clk_i); while (!s_tready);
    cand_count++;
    rank_insert(w, tag);
    if (is_last) rank_emit();
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_ranks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic set_empty_weight(input weight_t w);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk_i);
    cfg_wr_en <= 1'b0;
    empty_w = w;
    cfg_count++;
    foreach (tie_pool[i])
      tie_pool[i] = (w == 0) ? '0 : weight_t'($urandom_range(w - 1, 0));
  endtask

  function automatic weight_t pick_weight();
    int unsigned r;
    r = $urandom_range(9, 0);
    if (empty_w == 0 || r < 2) return weight_t'($urandom);
    if (r < 5) return tie_pool[$urandom_range(3, 0)];
    return weight_t'($urandom_range(empty_w - 1, 0));
  endfunction

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  // weight equal to the reset empty weight is dropped, frame comes out empty
  task automatic test_empty_frame();
    send_cand(EMPTY_WEIGHT_RST, TAG_MAX, 1'b1);
  endtask

  // equal weights keep arrival order, extremes of weight and tag
  task automatic test_tie_order();
    send_cand(weight_t'(300), tag_t'(1), 1'b0);
    send_cand(weight_t'(100), tag_t'(2), 1'b0);
    send_cand(weight_t'(300), TAG_MAX, 1'b0);
    send_cand('0, tag_t'(4), 1'b0);
    send_cand(weight_t'(EMPTY_WEIGHT_RST - 1), '0, 1'b0);
    send_cand(weight_t'(300), tag_t'(6), 1'b0);
    send_cand(weight_t'(200), tag_t'(7), 1'b1);
  endtask

  // more candidates than slots: tail falls off, a full list drops the worst
  task automatic test_list_overflow();
    set_empty_weight(WEIGHT_MAX);
    for (int i = 0; i < 10; i++)
      send_cand(weight_t'(WEIGHT_MAX - 1 - 37 * i), tag_t'(100 + i), 1'b0);
    send_cand(weight_t'(WEIGHT_MAX - 1), tag_t'(200), 1'b0);
    send_cand(WEIGHT_MAX, TAG_MAX, 1'b1);
  endtask

  // empty weight lowered under held entries: no re-sort, new items still compare
  task automatic test_weight_lowered();
    send_cand(weight_t'(50000), tag_t'(11), 1'b0);
    send_cand(weight_t'(60000), tag_t'(12), 1'b0);
    set_empty_weight(weight_t'(1000));
    send_cand(weight_t'(500), tag_t'(13), 1'b0);
    send_cand(weight_t'(1000), tag_t'(14), 1'b0);
    send_cand(weight_t'(70000), tag_t'(15), 1'b0);
    send_cand(weight_t'(999), tag_t'(16), 1'b1);
  endtask

  // empty weight of zero drops everything
  task automatic test_zero_empty();
    set_empty_weight('0);
    send_cand('0, tag_t'(21), 1'b0);
    send_cand('0, TAG_MAX, 1'b1);
  endtask

  task automatic test_random_frames(input weight_t ew, input rx_mode_e mode,
                                    input bit gaps, input int unsigned n_items);
    int unsigned left;
    int unsigned frame_len;
    set_empty_weight(ew);
    rx_mode = mode;
    tx_gaps = gaps;
    left = n_items;
    while (left != 0) begin
      frame_len = $urandom_range(24, 1);
      if (frame_len > left) frame_len = left;
      for (int i = 1; i <= frame_len; i++)
        send_cand(pick_weight(), tag_t'($urandom_range(TAG_MAX, 0)), i == frame_len);
      left -= frame_len;
    end
  endtask

  initial begin
    foreach (held_used[i]) begin
      held_used[i]   = 1'b0;
      held_weight[i] = EMPTY_WEIGHT_RST;
      held_tag[i]    = '0;
    end
    foreach (tie_pool[i]) tie_pool[i] = weight_t'($urandom_range(EMPTY_WEIGHT_RST - 1, 0));
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_frame();
    tx_gaps = 1'b1;
    rx_mode = RX_RANDOM;
    test_tie_order();
    test_list_overflow();
    test_weight_lowered();
    test_zero_empty();

    test_random_frames(WEIGHT_MAX, RX_RANDOM, 1'b1, 40);
    test_random_frames(EMPTY_WEIGHT_RST, RX_OPEN, 1'b0, 30);
    test_random_frames(weight_t'(64), RX_PATTERN, 1'b1, 30);
    test_random_frames(weight_t'($urandom), RX_SLOW, 1'b1, 30);
    test_random_frames(weight_t'(1), RX_RANDOM, 1'b0, 10);
    test_random_frames(WEIGHT_MAX, RX_OPEN, 1'b1, 12);

    s_tvalid <= 1'b0;
    while (expected_ranks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d candidates in %0d frames, checked %0d ranks", cand_count,
             frame_count, rank_count);
    $display("Empty weight rewritten %0d times, %0d field mismatches", cfg_count,
             mismatch_count);
    if (fail_count == 0 && expected_ranks.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/tkil_pkg.sv
hw/rtl/tkil_cell.sv
hw/rtl/tkil_ctrl.sv
hw/rtl/top_k_insertion_list.sv
hw/rtl/tkil_checker.sv
tb/top_k_insertion_list_test.sv
